// File: hw/rtl/cltok_pkg.sv
package cltok_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int LIMIT_W = 10;

    // Slot counter wraps once a token completes at this count
    localparam int MAX_SLOTS = 512;

    // Most results one byte can cause
    localparam int RES_MAX = 3;

    // Dependent feed passes needed for the longest re-feed chain
    localparam int FEED_PASSES = 3;

    localparam int CNT_W = 2;

    // Byte codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_HIGH   = 8'h80;

    localparam logic [SLOT_W-1:0] TD_SAT = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  value;
        logic [SLOT_W-1:0]  number;
        logic               last;
    } t_res;

    // Results of one item, oldest in entry 0
    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        t_res [RES_MAX-1:0] res;
    } t_res_set;

endpackage

// File: hw/rtl/cltok_core.sv
module cltok_core
    import cltok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LIMIT_W-1:0]  i_cfg_wr_data,
    input  logic                i_fire,
    input  logic [CHAR_W-1:0]   i_byte,
    output t_res_set            o_set
);

    typedef enum logic [6:0] {
        MODE_TOP   = 7'b0000001,
        MODE_SEP   = 7'b0000010,
        MODE_PLAIN = 7'b0000100,
        MODE_QUOTE = 7'b0001000,
        MODE_BLOCK = 7'b0010000,
        MODE_LINE  = 7'b0100000,
        MODE_VERB  = 7'b1000000
    } t_mode;

    t_mode               r_mode,  n_mode;
    logic                r_slash, n_slash;
    logic                r_bs,    n_bs;
    logic                r_star,  n_star;
    logic                r_skip,  n_skip;
    logic [SLOT_W-1:0]   r_td,    n_td;
    logic [SLOT_W-1:0]   r_slot,  n_slot;
    logic [LIMIT_W-1:0]  r_limit;

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return (c != CH_NUL) && ((c <= CH_SPACE) || (c >= CH_HIGH));
    endfunction

    function automatic t_res mk(input t_kind k, input logic [CHAR_W-1:0] v,
                                input logic [SLOT_W-1:0] n);
        t_res r;
        r.kind   = k;
        r.value  = v;
        r.number = n;
        r.last   = 1'b0;
        return r;
    endfunction

    // Drops anything past the third result
    function automatic t_res_set push(input t_res_set s, input t_res r);
        t_res_set t;
        t = s;
        if (t.cnt < CNT_W'(RES_MAX)) begin
            t.res[t.cnt] = r;
            t.cnt        = t.cnt + 2'd1;
        end
        return t;
    endfunction

    t_res_set           v_set;
    t_mode              v_m0;
    logic [CHAR_W-1:0]  v_c, v_c2;
    logic               v_has2, v_busy, v_go, v_ld, v_known;

    always_comb begin
        n_mode  = r_mode;
        n_slash = r_slash;
        n_bs    = r_bs;
        n_star  = r_star;
        n_skip  = r_skip;
        n_td    = r_td;
        n_slot  = r_slot;
        v_set   = '0;
        v_m0    = MODE_TOP;
        v_c     = i_byte;
        v_c2    = CH_NUL;
        v_has2  = 1'b0;
        v_busy  = 1'b1;
        v_go    = 1'b0;
        v_ld    = 1'b0;
        v_known = 1'b1;
        for (int p = 0; p < FEED_PASSES; p++) begin
            if (v_busy) begin
                v_busy = 1'b0;
                case (n_mode)
                    MODE_TOP, MODE_SEP, MODE_PLAIN, MODE_QUOTE,
                    MODE_BLOCK, MODE_LINE, MODE_VERB: v_known = 1'b1;
                    default: v_known = 1'b0;
                endcase
                if (!v_known) begin
                    n_mode  = MODE_TOP;
                    n_slash = 1'b0;
                    n_bs    = 1'b0;
                    n_skip  = 1'b0;
                end
                v_m0 = n_mode;

                // Token boundary: close a quoted token, then limit check
                if (n_mode == MODE_TOP) begin
                    v_go = 1'b1;
                    if (n_skip) begin
                        n_skip = 1'b0;
                        if (v_c == CH_NUL) begin
                            v_ld = 1'b1;
                            v_go = 1'b0;
                        end else begin
                            if (n_td != TD_SAT) n_td = n_td + 10'd1;
                            if (n_slot >= SLOT_W'(MAX_SLOTS)) n_slot = '0;
                            if (is_sep(v_c)) v_go = 1'b0;
                        end
                    end
                    if (v_go) begin
                        if (r_limit != '0 && n_td == r_limit - 10'd1) begin
                            if (v_c == CH_NUL) begin
                                v_ld = 1'b1;
                            end else begin
                                n_mode = MODE_VERB;
                                n_slot = n_slot + 10'd1;
                                v_set  = push(v_set, mk(KIND_BYTE, v_c, n_slot - 10'd1));
                            end
                        end else begin
                            n_mode = MODE_SEP;
                        end
                    end
                end

                if (n_mode == MODE_SEP) begin
                    if (n_slash) begin
                        n_slash = 1'b0;
                        if (v_c == CH_SLASH) begin
                            n_mode = MODE_LINE;
                        end else if (v_c == CH_STAR) begin
                            n_mode = MODE_BLOCK;
                            n_star = 1'b1;
                        end else begin
                            n_mode = MODE_PLAIN;
                            n_slot = n_slot + 10'd1;
                            v_set  = push(v_set, mk(KIND_BYTE, CH_SLASH, n_slot - 10'd1));
                            v_busy = 1'b1;
                        end
                    end else if (v_c == CH_NUL) begin
                        v_ld = 1'b1;
                    end else if (is_sep(v_c)) begin
                        n_mode = MODE_SEP;
                    end else if (v_c == CH_SLASH) begin
                        n_slash = 1'b1;
                    end else if (v_c == CH_DQUOTE) begin
                        n_mode = MODE_QUOTE;
                        n_slot = n_slot + 10'd1;
                    end else begin
                        n_mode = MODE_PLAIN;
                        n_slot = n_slot + 10'd1;
                        v_set  = push(v_set, mk(KIND_BYTE, v_c, n_slot - 10'd1));
                    end
                end else begin
                    case (v_m0)
                        MODE_PLAIN: begin
                            if (n_slash) begin
                                n_slash = 1'b0;
                                if (v_c == CH_SLASH || v_c == CH_STAR) begin
                                    // comment opener ends the token; re-feed both bytes
                                    v_set = push(v_set, mk(KIND_END, CH_NUL, n_slot - 10'd1));
                                    if (n_td != TD_SAT) n_td = n_td + 10'd1;
                                    if (n_slot >= SLOT_W'(MAX_SLOTS)) n_slot = '0;
                                    n_mode = MODE_TOP;
                                    v_c2   = v_c;
                                    v_c    = CH_SLASH;
                                    v_has2 = 1'b1;
                                    v_busy = 1'b1;
                                end else begin
                                    v_set  = push(v_set, mk(KIND_BYTE, CH_SLASH, n_slot - 10'd1));
                                    v_busy = 1'b1;
                                end
                            end else if (v_c == CH_NUL) begin
                                v_set = push(v_set, mk(KIND_END, CH_NUL, n_slot - 10'd1));
                                v_ld  = 1'b1;
                            end else if (is_sep(v_c) || v_c == CH_DQUOTE) begin
                                v_set = push(v_set, mk(KIND_END, CH_NUL, n_slot - 10'd1));
                                if (n_td != TD_SAT) n_td = n_td + 10'd1;
                                if (n_slot >= SLOT_W'(MAX_SLOTS)) n_slot = '0;
                                n_mode = MODE_TOP;
                                v_busy = (v_c == CH_DQUOTE);
                            end else if (v_c == CH_SLASH) begin
                                n_slash = 1'b1;
                            end else begin
                                v_set = push(v_set, mk(KIND_BYTE, v_c, n_slot - 10'd1));
                            end
                        end
                        MODE_QUOTE: begin
                            if (n_bs) begin
                                n_bs = 1'b0;
                                if (v_c != CH_DQUOTE) begin
                                    v_set  = push(v_set, mk(KIND_BYTE, CH_BSLASH, n_slot - 10'd1));
                                    v_busy = 1'b1;
                                end
                            end else if (v_c == CH_NUL) begin
                                v_set = push(v_set, mk(KIND_END, CH_NUL, n_slot - 10'd1));
                                v_ld  = 1'b1;
                            end else if (v_c == CH_DQUOTE) begin
                                v_set  = push(v_set, mk(KIND_END, CH_NUL, n_slot - 10'd1));
                                n_skip = 1'b1;
                                n_mode = MODE_TOP;
                            end else if (v_c == CH_BSLASH) begin
                                n_bs = 1'b1;
                            end else begin
                                v_set = push(v_set, mk(KIND_BYTE, v_c, n_slot - 10'd1));
                            end
                        end
                        MODE_BLOCK: begin
                            if (v_c == CH_NUL) begin
                                v_ld = 1'b1;
                            end else if (n_star && v_c == CH_SLASH) begin
                                n_star = 1'b0;
                                n_mode = MODE_TOP;
                            end else begin
                                n_star = (v_c == CH_STAR);
                            end
                        end
                        MODE_LINE: begin
                            v_ld = (v_c == CH_NUL);
                        end
                        MODE_VERB: begin
                            if (v_c == CH_NUL) begin
                                v_set = push(v_set, mk(KIND_END, CH_NUL, n_slot - 10'd1));
                                v_ld  = 1'b1;
                            end else begin
                                v_set = push(v_set, mk(KIND_BYTE, v_c, n_slot - 10'd1));
                            end
                        end
                        default: begin
                            v_go = 1'b0;
                        end
                    endcase
                end

                if (v_ld) begin
                    v_busy = 1'b0;
                end else if (!v_busy && v_has2) begin
                    v_c    = v_c2;
                    v_has2 = 1'b0;
                    v_busy = 1'b1;
                end
            end
        end

        // Line done: report count, fresh line
        if (v_ld) begin
            v_set   = push(v_set, mk(KIND_DONE, CH_NUL, n_slot));
            n_mode  = MODE_TOP;
            n_slash = 1'b0;
            n_bs    = 1'b0;
            n_star  = 1'b0;
            n_skip  = 1'b0;
            n_td    = '0;
            n_slot  = '0;
        end
        if (v_set.cnt != '0) begin
            v_set.res[v_set.cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_set = v_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TOP;
            r_slash <= 1'b0;
            r_bs    <= 1'b0;
            r_star  <= 1'b0;
            r_skip  <= 1'b0;
            r_td    <= '0;
            r_slot  <= '0;
            r_limit <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_mode  <= n_mode;
                r_slash <= n_slash;
                r_bs    <= n_bs;
                r_star  <= n_star;
                r_skip  <= n_skip;
                r_td    <= n_td;
                r_slot  <= n_slot;
            end
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(MAX_SLOTS))
        else $error("slot count beyond wrap point");

    a_pending_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_slash && r_bs))
        else $error("slash and backslash pending together");

    a_star_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star |-> r_mode == MODE_BLOCK)
        else $error("star flag held outside a block comment");

endmodule

// File: hw/rtl/cltok_outq.sv
module cltok_outq
    import cltok_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_res_set  i_set,
    input  logic      i_ready,
    output logic      o_free,
    output logic      o_valid,
    output t_res      o_head
);

    logic [CNT_W-1:0]   r_cnt;
    t_res [RES_MAX-1:0] r_buf;
    logic               w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_buf[0];
    assign w_pop   = o_valid && i_ready;
    // Empty now, or empty after this cycle's transfer
    assign o_free  = (r_cnt == '0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_set.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_set.res;
        end else if (w_pop) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("results loaded over undelivered ones");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_buf[0].last)
        else $error("final buffered result lacks last flag");

    a_last_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt > 2'd1 |-> !r_buf[0].last)
        else $error("last flag ahead of remaining results");

endmodule

// File: hw/rtl/command_line_tokenizer.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] char_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata value,number; tuser kind; tlast
// cfg       in   i_cfg_wr_en (no wait)        i_cfg_wr_data[9:0] token_limit
//
// One item a cycle is taken in while each byte yields at most one result and
// the output is not stalled. Each byte is held in the input register, then
// passes through the tokenizer logic into the result buffer; results leave
// one a cycle while m_axis_tready is high. A byte giving two or three results
// holds the input while the buffer drains. Reset is synchronous; it clears
// control state, not data registers. Stalls back up via the buffer to s_axis_tready.
module command_line_tokenizer
    import cltok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_wr_en,
    input  logic [LIMIT_W-1:0]  i_cfg_wr_data,   // token_limit
    // input bytes
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,    // [7:0] char_byte
    // results
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,    // [7:0] value, [17:8] number, rest 0
    output logic [1:0]          m_axis_tuser,    // [1:0] kind
    output logic                m_axis_tlast     // final result of the item
);

    // Input register
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_byte;

    logic               w_free;
    logic               w_load;
    t_res_set           w_set;
    t_res               w_head;

    // Item leaves the input register once the buffer can take all its results
    assign w_load        = r_in_valid && w_free;
    assign s_axis_tready = !r_in_valid || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Scanner state and per-byte result logic
    cltok_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_load),
        .i_byte        (r_in_byte),
        .o_set         (w_set)
    );

    // Result buffer, up to three per item
    cltok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_set   (w_set),
        .i_ready (m_axis_tready),
        .o_free  (w_free),
        .o_valid (m_axis_tvalid),
        .o_head  (w_head)
    );

    assign m_axis_tdata = {6'b0, w_head.number, w_head.value};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import cltok_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 120;    // long output stall, block must back up
    localparam int SHOW_MAX    = 40;     // cap on printed mismatch lines

    // Where the tokenizer stands between bytes
    typedef enum logic [2:0] {
        SCAN_TOP,      // token boundary, before separator skipping
        SCAN_SEP,      // skipping separators
        SCAN_PLAIN,    // inside an unquoted token
        SCAN_QUOTE,    // inside a quoted token
        SCAN_BLOCK,    // inside a block comment
        SCAN_LINE,     // after a line comment, ignore up to the NUL
        SCAN_VERB      // last token, rest of line taken as is
    } t_scan;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;      // [7:0] char_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;           // [7:0] value, [17:8] number
    logic [1:0]          m_axis_tuser;           // [1:0] kind
    logic                m_axis_tlast;

    command_line_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tokenizer model state, a mirror of what the block should hold
    // ------------------------------------------------------------------
    t_scan               scan = SCAN_TOP;
    logic                slash_held = 1'b0;      // '/' waiting for the next byte
    logic                bslash_held = 1'b0;     // '\' waiting inside quotes
    logic                star_held = 1'b0;       // last comment byte was '*'
    logic                eat_sep = 1'b0;         // one separator after a closing quote
    logic [SLOT_W-1:0]   toks_closed = '0;
    logic [SLOT_W-1:0]   slots_open = '0;
    logic [LIMIT_W-1:0]  tok_limit = '0;

    t_res                step_res [RES_MAX];
    int                  step_n;
    t_res                results_due [$];        // expected results, oldest first
    logic [7:0]          line_bytes [$];         // bytes waiting for the driver

    int                  send_idle_pct = 24;
    int                  recv_idle_pct = 74;
    int                  hold_left = 0;
    bit                  hold_used = 0;
    int                  mismatches = 0;
    int                  bytes_sent = 0;
    int                  bytes_queued = 0;
    int                  results_seen = 0;
    int                  lines_seen = 0;
    int                  cfg_writes = 0;
    int                  cycle_cnt = 0;

    function automatic void emit(t_kind k, logic [7:0] v, logic [SLOT_W-1:0] n);
        if (step_n < RES_MAX) begin
            step_res[step_n] = '{kind: k, value: v, number: n, last: 1'b0};
            step_n++;
        end
    endfunction

    function automatic void emit_byte(logic [7:0] c);
        emit(KIND_BYTE, c, slots_open - 1'b1);
    endfunction

    function automatic void emit_end();
        emit(KIND_END, 8'h00, slots_open - 1'b1);
    endfunction

    // Token complete: count it (saturating) and wrap the slot number
    function automatic void close_token();
        if (toks_closed != TD_SAT)
            toks_closed++;
        if (slots_open >= MAX_SLOTS)
            slots_open = '0;
    endfunction

    // NUL seen: report the count, start a fresh line
    function automatic void line_end();
        emit(KIND_DONE, 8'h00, slots_open);
        scan        = SCAN_TOP;
        slash_held  = 1'b0;
        bslash_held = 1'b0;
        star_held   = 1'b0;
        eat_sep     = 1'b0;
        toks_closed = '0;
        slots_open  = '0;
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        return c != CH_NUL && (c <= CH_SPACE || c >= CH_HIGH);
    endfunction

    // Works out the results of one byte and queues them. A byte that has to be
    // looked at again in a new scan state stays at the head of the work list; a
    // held '/' that turns out to open a comment after a plain token is pushed
    // back in front of the current byte.
    function automatic void tokenize_byte(logic [7:0] c_in);
        logic [7:0] pend [$];
        logic [7:0] c;
        bit         refeed;
        step_n = 0;
        pend.push_back(c_in);
        while (pend.size() > 0) begin
            c = pend[0];
            refeed = 1'b0;
            case (scan)
                SCAN_TOP: begin
                    refeed = 1'b1;
                    if (eat_sep) begin
                        eat_sep = 1'b0;
                        if (c == CH_NUL) begin
                            line_end();
                            refeed = 1'b0;
                        end else begin
                            close_token();
                            if (is_sep(c))
                                refeed = 1'b0;
                        end
                    end
                    if (refeed) begin
                        if (tok_limit != 0 && toks_closed == tok_limit - 1'b1) begin
                            refeed = 1'b0;
                            if (c == CH_NUL) begin
                                line_end();
                            end else begin
                                scan = SCAN_VERB;
                                slots_open++;
                                emit_byte(c);
                            end
                        end else begin
                            scan = SCAN_SEP;
                        end
                    end
                end
                SCAN_SEP: begin
                    if (slash_held) begin
                        slash_held = 1'b0;
                        if (c == CH_SLASH) begin
                            scan = SCAN_LINE;
                        end else if (c == CH_STAR) begin
                            scan = SCAN_BLOCK;
                            star_held = 1'b1;
                        end else begin
                            scan = SCAN_PLAIN;
                            slots_open++;
                            emit_byte(CH_SLASH);
                            refeed = 1'b1;
                        end
                    end else if (c == CH_NUL) begin
                        line_end();
                    end else if (!is_sep(c)) begin
                        if (c == CH_SLASH) begin
                            slash_held = 1'b1;
                        end else if (c == CH_DQUOTE) begin
                            scan = SCAN_QUOTE;
                            slots_open++;
                        end else begin
                            scan = SCAN_PLAIN;
                            slots_open++;
                            emit_byte(c);
                        end
                    end
                end
                SCAN_PLAIN: begin
                    if (slash_held) begin
                        slash_held = 1'b0;
                        refeed = 1'b1;
                        if (c == CH_SLASH || c == CH_STAR) begin
                            // comment opener ends the token, then both bytes rescanned
                            emit_end();
                            close_token();
                            scan = SCAN_TOP;
                            void'(pend.pop_front());
                            pend.push_front(c);
                            pend.push_front(CH_SLASH);
                        end else begin
                            emit_byte(CH_SLASH);
                        end
                    end else if (c == CH_NUL) begin
                        emit_end();
                        line_end();
                    end else if (is_sep(c) || c == CH_DQUOTE) begin
                        emit_end();
                        close_token();
                        scan = SCAN_TOP;
                        refeed = (c == CH_DQUOTE);
                    end else if (c == CH_SLASH) begin
                        slash_held = 1'b1;
                    end else begin
                        emit_byte(c);
                    end
                end
                SCAN_QUOTE: begin
                    if (bslash_held) begin
                        bslash_held = 1'b0;
                        // escaped quote vanishes, a lone backslash is kept
                        if (c != CH_DQUOTE) begin
                            emit_byte(CH_BSLASH);
                            refeed = 1'b1;
                        end
                    end else if (c == CH_NUL) begin
                        emit_end();
                        line_end();
                    end else if (c == CH_DQUOTE) begin
                        emit_end();
                        eat_sep = 1'b1;
                        scan = SCAN_TOP;
                    end else if (c == CH_BSLASH) begin
                        bslash_held = 1'b1;
                    end else begin
                        emit_byte(c);
                    end
                end
                SCAN_BLOCK: begin
                    if (c == CH_NUL) begin
                        line_end();
                    end else if (star_held && c == CH_SLASH) begin
                        star_held = 1'b0;
                        scan = SCAN_TOP;
                    end else begin
                        star_held = (c == CH_STAR);
                    end
                end
                SCAN_LINE: begin
                    if (c == CH_NUL)
                        line_end();
                end
                SCAN_VERB: begin
                    if (c == CH_NUL) begin
                        emit_end();
                        line_end();
                    end else begin
                        emit_byte(c);
                    end
                end
                default: begin
                    scan = SCAN_TOP;
                    slash_held = 1'b0;
                    bslash_held = 1'b0;
                    eat_sep = 1'b0;
                    refeed = 1'b1;
                end
            endcase
            if (!refeed)
                void'(pend.pop_front());
        end
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            results_due.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------
    // Driver: holds tvalid and tdata steady until the item is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                tokenize_byte(s_axis_tdata);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (line_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= line_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag(string what, int unsigned exp_v, int unsigned got_v);
        if (mismatches < SHOW_MAX)
            $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor and receiver: checks each result, throttles tready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res due;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    if (mismatches < SHOW_MAX)
                        $display("%0t: unexpected result, expected none got kind %0d value %0d",
                                 $time, m_axis_tuser, m_axis_tdata[7:0]);
                    mismatches++;
                end else begin
                    due = results_due.pop_front();
                    if (due.kind == KIND_DONE)
                        lines_seen++;
                    if (m_axis_tuser !== due.kind)
                        flag("kind", due.kind, m_axis_tuser);
                    if (m_axis_tdata[7:0] !== due.value)
                        flag("value", due.value, m_axis_tdata[7:0]);
                    if (m_axis_tdata[17:8] !== due.number)
                        flag("number", due.number, m_axis_tdata[17:8]);
                    if (m_axis_tdata[23:18] !== 6'd0)
                        flag("tdata padding", 0, m_axis_tdata[23:18]);
                    if (m_axis_tlast !== due.last)
                        flag("last", due.last, m_axis_tlast);
                end
            end
            // first time the receiver stops idling, stall it hard once
            if (!hold_used && recv_idle_pct == 0) begin
                hold_used     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b);
        line_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Block is idle: nothing queued, nothing in flight, nothing due
    task automatic wait_idle();
        while (line_bytes.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tok_limit      = v;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_DQUOTE || c == CH_SLASH);
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        return $urandom_range(0, 1) ? 8'($urandom_range(1, 32)) : 8'($urandom_range(128, 255));
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_DQUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // One line built from random pieces: mostly well formed words, quotes and
    // comments, with unclosed quotes/comments, stray bytes and noise mixed in.
    task automatic gen_line();
        int pieces;
        pieces = $urandom_range(0, 8);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 6)) push_byte(word_char());
                    if ($urandom_range(0, 3) == 0) begin
                        push_byte(CH_SLASH);
                        push_byte(word_char());
                    end
                end
                3, 4: repeat ($urandom_range(1, 3)) push_byte(sep_char());
                5: begin
                    push_byte(CH_DQUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 3))
                            0: push_byte(CH_BSLASH);
                            1: begin
                                push_byte(CH_BSLASH);
                                push_byte(CH_DQUOTE);
                            end
                            default: push_byte(quoted_char());
                        endcase
                    end
                    if ($urandom_range(0, 9) < 8)
                        push_byte(CH_DQUOTE);
                end
                6: begin
                    push_byte(CH_SLASH);
                    push_byte(CH_STAR);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 3))
                            0: push_byte(CH_STAR);
                            1: push_byte(CH_SLASH);
                            2: push_byte(CH_SPACE);
                            default: push_byte(word_char());
                        endcase
                    end
                    if ($urandom_range(0, 9) < 8) begin
                        push_byte(CH_STAR);
                        push_byte(CH_SLASH);
                    end
                end
                7: begin
                    push_byte(CH_SLASH);
                    push_byte(CH_SLASH);
                    repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
                end
                8: repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(1, 255)));
                default: begin
                    case ($urandom_range(0, 3))
                        0: push_byte(CH_SLASH);
                        1: push_byte(CH_BSLASH);
                        2: push_byte(CH_STAR);
                        default: push_byte(CH_DQUOTE);
                    endcase
                end
            endcase
        end
        push_byte(CH_NUL);
    endtask

    task automatic random_lines(int n_items);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < n_items)
            gen_line();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, limit 0: quote ending a plain token, escaped quote dropped,
        // lone backslash kept, separator after the closing quote eaten (a high
        // byte), slash inside a token, "/*/" as a whole comment ending a token,
        // and "//" ending the line.
        push_text("a\"b\\\"\\c\"");
        push_byte(8'hFF);
        push_text("d/e/*/f//g");
        push_byte(CH_NUL);

        // Limit 2: second token is verbatim from the boundary, separators and
        // comment openers included; 0x7F is part of a word.
        set_limit(10'd2);
        push_text(" x");
        push_byte(8'h7F);
        push_text(" ");
        push_byte(8'h01);
        push_text("y/*");
        push_byte(CH_NUL);

        // Random lines over several limits and idling patterns
        set_limit(10'd1);
        random_lines(65);
        set_limit(10'd3);
        random_lines(65);
        set_limit(10'(MAX_SLOTS));
        send_idle_pct = 74;
        recv_idle_pct = 24;
        random_lines(65);
        set_limit(10'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;     // receiver starts with its long stall here
        random_lines(65);

        wait_idle();
        $display("Run: %0d bytes in, %0d results checked, %0d lines, %0d limit writes",
                 bytes_sent, results_seen, lines_seen, cfg_writes);
        $display("Covered quotes, comments, verbatim tails and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
